[rtl/ipv4hc_pkg.sv]
// Package for the IPv4 header check and TTL update block.
// Holds the request payload types, verdict codes and the ones-complement adder.
// No dependencies.
package ipv4hc_pkg;

    localparam int LOCAL_ADDRS = 4;
    localparam int CFG_ADDR_W  = 5;

    localparam logic [2:0] REG_LOCAL_ADDR_0 = 3'd0;
    localparam logic [2:0] REG_LOCAL_ADDR_1 = 3'd1;
    localparam logic [2:0] REG_LOCAL_ADDR_2 = 3'd2;
    localparam logic [2:0] REG_LOCAL_ADDR_3 = 3'd3;
    localparam logic [2:0] REG_LOCAL_COUNT  = 3'd4;

    localparam logic [2:0] VERDICT_FORWARD      = 3'd0;
    localparam logic [2:0] VERDICT_LOCAL        = 3'd1;
    localparam logic [2:0] VERDICT_NOT_IPV4     = 3'd2;
    localparam logic [2:0] VERDICT_BAD_HDR_LEN  = 3'd3;
    localparam logic [2:0] VERDICT_BAD_LENGTH   = 3'd4;
    localparam logic [2:0] VERDICT_TTL_EXCEEDED = 3'd5;
    localparam logic [2:0] VERDICT_BAD_CHECKSUM = 3'd6;

    localparam logic [3:0]  IP_VERSION_4   = 4'd4;
    localparam logic [3:0]  MIN_IHL        = 4'd5;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [15:0] TTL_DEC_ADDEND = 16'hFEFF;

    localparam logic [4:0] WORD_TOTAL_LEN = 5'd1;
    localparam logic [4:0] WORD_TTL_PROTO = 5'd4;
    localparam logic [4:0] WORD_CHECKSUM  = 5'd5;
    localparam logic [4:0] WORD_DEST_HI   = 5'd8;
    localparam logic [4:0] WORD_DEST_LO   = 5'd9;

    typedef struct packed {
        logic [15:0] header_word;
        logic        first_word;
        logic [15:0] ip_length;
        logic        on_link;
    } in_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic        is_tcp;
        logic [7:0]  new_ttl;
        logic [15:0] new_checksum;
        logic [31:0] destination;
    } out_t;

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

[rtl/ipv4_header_check_and_ttl_update.sv]
// Top level of the IPv4 header check and TTL update block.
// Depends on ipv4hc_pkg for payload types, verdict codes and the ones-complement adder.

// The block takes one 16-bit header word per cycle and gives at most one verdict per
// header; each request passes an input register and then the header state update and
// verdict logic into a result register, which presents the verdict of the request that
// completes the header, and a new word is accepted every cycle while the result side
// keeps up. Addresses and the address count are to be written by the user over the APB
// port only while no header is in flight; the block itself does not enforce this.
module ipv4_header_check_and_ttl_update (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ipv4hc_pkg::in_t                     s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ipv4hc_pkg::out_t                    m_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ipv4hc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic [31:0] local_addr_reg [ipv4hc_pkg::LOCAL_ADDRS];
    logic [2:0]  local_count_reg;
    logic [2:0]  reg_index;
    logic        cfg_write;

    ipv4hc_pkg::in_t  in_data_reg;
    logic             in_valid_reg;
    logic             in_valid_next;
    ipv4hc_pkg::out_t out_data_reg;
    ipv4hc_pkg::out_t out_data_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             proc_fire;
    logic             emit;

    logic [4:0]  word_count_reg, word_count_next;
    logic [3:0]  header_words_reg, header_words_next;
    logic [15:0] running_sum_reg, running_sum_next;
    logic [15:0] total_len_reg, total_len_next;
    logic [15:0] stored_sum_reg, stored_sum_next;
    logic [7:0]  ttl_reg, ttl_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] dest_reg, dest_next;
    logic [15:0] length_avail_reg, length_avail_next;
    logic        link_flag_reg, link_flag_next;
    logic        version_ok_reg, version_ok_next;
    logic        skipping_reg, skipping_next;

    logic [2:0]  count_used;
    logic        dest_local;
    logic [7:0]  ttl_dec;
    logic [15:0] fwd_sum;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ipv4hc_pkg::LOCAL_ADDRS; i++) begin
                local_addr_reg[i] <= '0;
            end
            local_count_reg <= '0;
        end else if (cfg_write) begin
            unique case (reg_index)
                ipv4hc_pkg::REG_LOCAL_ADDR_0: local_addr_reg[0] <= pwdata;
                ipv4hc_pkg::REG_LOCAL_ADDR_1: local_addr_reg[1] <= pwdata;
                ipv4hc_pkg::REG_LOCAL_ADDR_2: local_addr_reg[2] <= pwdata;
                ipv4hc_pkg::REG_LOCAL_ADDR_3: local_addr_reg[3] <= pwdata;
                ipv4hc_pkg::REG_LOCAL_COUNT:  local_count_reg   <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            ipv4hc_pkg::REG_LOCAL_ADDR_0: prdata = local_addr_reg[0];
            ipv4hc_pkg::REG_LOCAL_ADDR_1: prdata = local_addr_reg[1];
            ipv4hc_pkg::REG_LOCAL_ADDR_2: prdata = local_addr_reg[2];
            ipv4hc_pkg::REG_LOCAL_ADDR_3: prdata = local_addr_reg[3];
            ipv4hc_pkg::REG_LOCAL_COUNT:  prdata = {29'd0, local_count_reg};
            default:                      prdata = '0;
        endcase
    end

    assign proc_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (proc_fire) begin
            in_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end
    end

    always_comb begin
        count_used = (local_count_reg > 3'(ipv4hc_pkg::LOCAL_ADDRS))
                   ? 3'(ipv4hc_pkg::LOCAL_ADDRS) : local_count_reg;
        dest_local = 1'b0;
        for (int i = 0; i < ipv4hc_pkg::LOCAL_ADDRS; i++) begin
            if ((3'(i) < count_used) && (local_addr_reg[i] == dest_next)) begin
                dest_local = 1'b1;
            end
        end
    end

    always_comb begin
        word_count_next   = word_count_reg;
        header_words_next = header_words_reg;
        running_sum_next  = running_sum_reg;
        total_len_next    = total_len_reg;
        stored_sum_next   = stored_sum_reg;
        ttl_next          = ttl_reg;
        proto_next        = proto_reg;
        dest_next         = dest_reg;
        length_avail_next = length_avail_reg;
        link_flag_next    = link_flag_reg;
        version_ok_next   = version_ok_reg;
        skipping_next     = skipping_reg;
        emit              = 1'b0;
        out_data_next     = '0;
        ttl_dec           = ttl_reg - 8'd1;
        fwd_sum           = '0;

        if (in_data_reg.first_word) begin
            version_ok_next   = (in_data_reg.header_word[15:12] == ipv4hc_pkg::IP_VERSION_4);
            header_words_next = in_data_reg.header_word[11:8];
            length_avail_next = in_data_reg.ip_length;
            link_flag_next    = in_data_reg.on_link;
            running_sum_next  = in_data_reg.header_word;
            total_len_next    = '0;
            stored_sum_next   = '0;
            ttl_next          = '0;
            proto_next        = '0;
            dest_next         = '0;
            word_count_next   = 5'd1;
            skipping_next     = 1'b0;
            if (in_data_reg.header_word[11:8] < ipv4hc_pkg::MIN_IHL) begin
                skipping_next         = 1'b1;
                emit                  = 1'b1;
                out_data_next.verdict = version_ok_next ? ipv4hc_pkg::VERDICT_BAD_HDR_LEN
                                                        : ipv4hc_pkg::VERDICT_NOT_IPV4;
            end
        end else if (!skipping_reg) begin
            if (word_count_reg == ipv4hc_pkg::WORD_CHECKSUM) begin
                stored_sum_next = in_data_reg.header_word;
            end else begin
                running_sum_next = ipv4hc_pkg::ones_add(running_sum_reg,
                                                        in_data_reg.header_word);
                if (word_count_reg == ipv4hc_pkg::WORD_TOTAL_LEN) begin
                    total_len_next = in_data_reg.header_word;
                end else if (word_count_reg == ipv4hc_pkg::WORD_TTL_PROTO) begin
                    ttl_next   = in_data_reg.header_word[15:8];
                    proto_next = in_data_reg.header_word[7:0];
                end else if (word_count_reg == ipv4hc_pkg::WORD_DEST_HI) begin
                    dest_next[31:16] = in_data_reg.header_word;
                end else if (word_count_reg == ipv4hc_pkg::WORD_DEST_LO) begin
                    dest_next[15:0] = in_data_reg.header_word;
                end
            end
            word_count_next = word_count_reg + 5'd1;

            if ({1'b0, word_count_reg} + 6'd1 >= {1'b0, header_words_reg, 1'b0}) begin
                skipping_next              = 1'b1;
                emit                       = 1'b1;
                ttl_dec                    = ttl_next - 8'd1;
                fwd_sum                    = ~ipv4hc_pkg::ones_add(running_sum_next,
                                                ipv4hc_pkg::TTL_DEC_ADDEND);
                out_data_next.is_tcp       = (proto_next == ipv4hc_pkg::PROTO_TCP);
                out_data_next.new_ttl      = ttl_next;
                out_data_next.new_checksum = stored_sum_next;
                out_data_next.destination  = dest_next;
                priority if (!version_ok_reg) begin
                    out_data_next.verdict = ipv4hc_pkg::VERDICT_NOT_IPV4;
                end else if (length_avail_reg < total_len_next) begin
                    out_data_next.verdict = ipv4hc_pkg::VERDICT_BAD_LENGTH;
                end else if (ttl_next == 8'd0) begin
                    out_data_next.verdict = ipv4hc_pkg::VERDICT_TTL_EXCEEDED;
                end else if (~running_sum_next != stored_sum_next) begin
                    out_data_next.verdict = ipv4hc_pkg::VERDICT_BAD_CHECKSUM;
                end else if (dest_local) begin
                    out_data_next.verdict = ipv4hc_pkg::VERDICT_LOCAL;
                end else if (ttl_dec > 8'd1 || (link_flag_reg && ttl_dec >= 8'd1)) begin
                    out_data_next.verdict      = ipv4hc_pkg::VERDICT_FORWARD;
                    out_data_next.new_ttl      = ttl_dec;
                    out_data_next.new_checksum = fwd_sum;
                end else begin
                    out_data_next.verdict = ipv4hc_pkg::VERDICT_TTL_EXCEEDED;
                end
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (proc_fire) begin
            out_valid_next = emit;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            word_count_reg   <= '0;
            header_words_reg <= '0;
            running_sum_reg  <= '0;
            total_len_reg    <= '0;
            stored_sum_reg   <= '0;
            ttl_reg          <= '0;
            proto_reg        <= '0;
            dest_reg         <= '0;
            length_avail_reg <= '0;
            link_flag_reg    <= 1'b0;
            version_ok_reg   <= 1'b0;
            skipping_reg     <= 1'b1;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (proc_fire) begin
                word_count_reg   <= word_count_next;
                header_words_reg <= header_words_next;
                running_sum_reg  <= running_sum_next;
                total_len_reg    <= total_len_next;
                stored_sum_reg   <= stored_sum_next;
                ttl_reg          <= ttl_next;
                proto_reg        <= proto_next;
                dest_reg         <= dest_next;
                length_avail_reg <= length_avail_next;
                link_flag_reg    <= link_flag_next;
                version_ok_reg   <= version_ok_next;
                skipping_reg     <= skipping_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (proc_fire && emit) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // The input side stalls only when both registers are full and the result waits.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a waiting result");

    // While a header is being collected, the word count stays inside the header.
    a_word_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        !skipping_reg |-> (header_words_reg >= ipv4hc_pkg::MIN_IHL
                           && {1'b0, word_count_reg} < {1'b0, header_words_reg, 1'b0}))
        else $error("word count outside the header");

    // A forwarded request always leaves with a live TTL.
    a_fwd_ttl: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.verdict == ipv4hc_pkg::VERDICT_FORWARD) |-> (m_data.new_ttl != 8'd0))
        else $error("forwarded request with zero TTL");

    // A header verdict ends the header, so the next word is ignored unless it is a first word.
    a_verdict_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && emit) |=> skipping_reg)
        else $error("header still open after its verdict");

endmodule
